@@ src/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the temperature sensor supervisor.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int ELAPSED_W = 10;
  localparam int INDEX_W   = 4;
  localparam int COUNT_W   = 5;
  localparam int MS_W      = 16;
  localparam int LIMIT_W   = 12;
  localparam int RUN_W     = 8;
  localparam int TIMER_W   = 17;
  localparam int CMP_W     = 33;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};
  localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};

  localparam logic signed [CMP_W-1:0] DISCONNECTED = -33'sd2032;

  localparam logic [MS_W-1:0]           READ_INTERVAL_RST = 16'd1000;
  localparam logic [MS_W-1:0]           CONVERSION_RST    = 16'd750;
  localparam logic signed [LIMIT_W-1:0] VALID_MIN_RST     = 12'sd0;
  localparam logic signed [LIMIT_W-1:0] VALID_MAX_RST     = 12'sd800;
  localparam logic [RUN_W-1:0]          ERROR_THR_RST     = 8'd3;
  localparam logic [RUN_W-1:0]          RECOVERY_THR_RST  = 8'd3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_PROC = 2'd2
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_READ_INTERVAL  = 3'd0,
    REG_CONVERSION     = 3'd1,
    REG_VALID_MIN      = 3'd2,
    REG_VALID_MAX      = 3'd3,
    REG_ERROR_THR      = 3'd4,
    REG_RECOVERY_THR   = 3'd5,
    REG_SENSOR_PRESENT = 3'd6
  } cfg_reg_t;

endpackage

@@ src/tss_upd_if.sv @@
// ----------------------------------------------------------------------------
// tss_upd_if
// Update channel: one word per update pass.
// ----------------------------------------------------------------------------
interface tss_upd_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                                  valid;
  logic                                  ready;
  logic [tss_pkg::ELAPSED_W-1:0]         elapsed_ms;
  logic signed [SAMPLE_BITS-1:0]         sensor_reading;
  logic [tss_pkg::INDEX_W-1:0]           history_index;

  modport source (output valid, output elapsed_ms, output sensor_reading,
                  output history_index, input ready);
  modport sink   (input valid, input elapsed_ms, input sensor_reading,
                  input history_index, output ready);
endinterface

@@ src/tss_rep_if.sv @@
// ----------------------------------------------------------------------------
// tss_rep_if
// Report channel: one status word per update pass.
// ----------------------------------------------------------------------------
interface tss_rep_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                          valid;
  logic                          ready;
  logic                          request_conversion;
  logic                          sample_taken;
  logic                          sample_accepted;
  logic signed [SAMPLE_BITS-1:0] current_temp;
  logic                          sensor_ok;
  logic [tss_pkg::RUN_W-1:0]     error_count;
  logic                          sensor_fault;
  logic [tss_pkg::COUNT_W-1:0]   history_count;
  logic signed [SAMPLE_BITS-1:0] history_value;
  logic                          history_hit;
  logic signed [SAMPLE_BITS-1:0] oldest_temp;
  logic signed [SAMPLE_BITS-1:0] newest_temp;

  modport source (output valid, output request_conversion, output sample_taken,
                  output sample_accepted, output current_temp, output sensor_ok,
                  output error_count, output sensor_fault, output history_count,
                  output history_value, output history_hit, output oldest_temp,
                  output newest_temp, input ready);
  modport sink   (input valid, input request_conversion, input sample_taken,
                  input sample_accepted, input current_temp, input sensor_ok,
                  input error_count, input sensor_fault, input history_count,
                  input history_value, input history_hit, input oldest_temp,
                  input newest_temp, output ready);
endinterface

@@ src/tss_ring.sv @@
// ----------------------------------------------------------------------------
// tss_ring
// History ring memory: one write port, two registered read ports with
// write-through for a read of the slot written in the same cycle.
// ----------------------------------------------------------------------------
module tss_ring #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 12
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_word,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_word_a,
  output logic [WIDTH-1:0]         rd_word_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_a <= (wr_en && wr_addr == rd_addr_a) ? wr_word : mem[rd_addr_a];
      rd_word_b <= (wr_en && wr_addr == rd_addr_b) ? wr_word : mem[rd_addr_b];
    end
  end

endmodule

@@ src/temp_sensor_supervisor.sv @@
// ----------------------------------------------------------------------------
// temp_sensor_supervisor
// Sensor health supervisor: conversion sequencer, reading validation,
// error and recovery runs, and a history ring of accepted readings.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  update    in    valid / ready    elapsed_ms, sensor_reading, history_index
//  report    out   valid / ready    health flags, counts, history entries
//  wr_*      in    wr_en            wr_index, wr_data (no read-back)
//
//  One update word per cycle while update.ready is high. Each report passes
//  through these stages once its word is taken: state and ring update at the
//  accept edge, ring reads land in a middle stage, then the report register.
//  The middle stage and the report register each hold a word; a stalled
//  report blocks the update input only once both are full.
//  rst is synchronous; the ring itself is not cleared, the fill count gates it.
// ----------------------------------------------------------------------------
module temp_sensor_supervisor #(
  parameter int RING_DEPTH  = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  tss_upd_if.sink                          update,
  tss_rep_if.source                        report,
  input  logic                             wr_en,
  input  logic [tss_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [tss_pkg::CFG_DATA_W-1:0]   wr_data
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int CW = (FW > tss_pkg::INDEX_W) ? FW : tss_pkg::INDEX_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [FW-1:0] FULL     = FW'(RING_DEPTH);

  typedef struct packed {
    logic                          request;
    logic                          taken;
    logic                          accepted;
    logic signed [SAMPLE_BITS-1:0] current;
    logic                          ok;
    logic [tss_pkg::RUN_W-1:0]     errors;
    logic                          fault;
    logic [FW-1:0]                 count;
    logic                          hit;
  } mid_t;

  typedef struct packed {
    logic                          request;
    logic                          taken;
    logic                          accepted;
    logic signed [SAMPLE_BITS-1:0] current;
    logic                          ok;
    logic [tss_pkg::RUN_W-1:0]     errors;
    logic                          fault;
    logic [tss_pkg::COUNT_W-1:0]   count;
    logic signed [SAMPLE_BITS-1:0] hist;
    logic                          hit;
    logic signed [SAMPLE_BITS-1:0] oldest;
    logic signed [SAMPLE_BITS-1:0] newest;
  } rep_t;

  // configuration
  logic [tss_pkg::MS_W-1:0]           read_interval_ms;
  logic [tss_pkg::MS_W-1:0]           conversion_ms;
  logic signed [tss_pkg::LIMIT_W-1:0] valid_min;
  logic signed [tss_pkg::LIMIT_W-1:0] valid_max;
  logic [tss_pkg::RUN_W-1:0]          error_threshold;
  logic [tss_pkg::RUN_W-1:0]          recovery_threshold;

  // supervisor state
  tss_pkg::phase_t               phase, phase_next;
  logic [tss_pkg::TIMER_W-1:0]   phase_timer, phase_timer_next, timer_sat;
  logic [tss_pkg::TIMER_W:0]     timer_sum;
  logic signed [SAMPLE_BITS-1:0] last_good_temp, last_good_temp_next;
  logic [tss_pkg::RUN_W-1:0]     bad_run, bad_run_next, bad_inc;
  logic [tss_pkg::RUN_W-1:0]     good_run, good_run_next, good_inc;
  logic                          operational, operational_next;
  logic [AW-1:0]                 write_slot, write_slot_next, ws_inc;
  logic [FW-1:0]                 filled, filled_next;

  logic                          accept;
  logic                          req_now, taken_now, in_range, accepted_now;
  logic signed [tss_pkg::CMP_W-1:0] reading_x;
  logic                          hit_now;
  logic [AW-1:0]                 addr_a, addr_b;
  logic [SAMPLE_BITS-1:0]        rd_a, rd_b;

  mid_t mid, mid_next;
  logic mid_valid, mid_adv;
  rep_t rep, rep_next;
  logic rep_valid;

  assign accept       = update.valid && update.ready;
  assign mid_adv      = !rep_valid || report.ready;
  assign update.ready = !mid_valid || mid_adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      read_interval_ms   <= tss_pkg::READ_INTERVAL_RST;
      conversion_ms      <= tss_pkg::CONVERSION_RST;
      valid_min          <= tss_pkg::VALID_MIN_RST;
      valid_max          <= tss_pkg::VALID_MAX_RST;
      error_threshold    <= tss_pkg::ERROR_THR_RST;
      recovery_threshold <= tss_pkg::RECOVERY_THR_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        tss_pkg::REG_READ_INTERVAL:  read_interval_ms   <= wr_data;
        tss_pkg::REG_CONVERSION:     conversion_ms      <= wr_data;
        tss_pkg::REG_VALID_MIN:      valid_min          <= $signed(wr_data[11:0]);
        tss_pkg::REG_VALID_MAX:      valid_max          <= $signed(wr_data[11:0]);
        tss_pkg::REG_ERROR_THR:      error_threshold    <= wr_data[7:0];
        tss_pkg::REG_RECOVERY_THR:   recovery_threshold <= wr_data[7:0];
        tss_pkg::REG_SENSOR_PRESENT: ;
        default: ;
      endcase
    end
  end

  // sequencer: next state
  always_comb begin
    timer_sum = {1'b0, phase_timer} + (tss_pkg::TIMER_W + 1)'(update.elapsed_ms);
    timer_sat = timer_sum[tss_pkg::TIMER_W] ? tss_pkg::TIMER_MAX
                                            : timer_sum[tss_pkg::TIMER_W-1:0];
    phase_next       = phase;
    phase_timer_next = timer_sat;
    unique case (phase)
      tss_pkg::PH_WAIT: begin
        if (timer_sat >= tss_pkg::TIMER_W'(conversion_ms)) begin
          phase_next = tss_pkg::PH_PROC;
        end
      end
      tss_pkg::PH_PROC: begin
        phase_next       = tss_pkg::PH_IDLE;
        phase_timer_next = '0;
      end
      default: begin
        phase_next = tss_pkg::PH_IDLE;
        if (timer_sat >= tss_pkg::TIMER_W'(read_interval_ms)) begin
          phase_next       = tss_pkg::PH_WAIT;
          phase_timer_next = '0;
        end
      end
    endcase
  end

  // sequencer: outputs
  always_comb begin
    req_now   = 1'b0;
    taken_now = 1'b0;
    unique case (phase)
      tss_pkg::PH_WAIT: ;
      tss_pkg::PH_PROC: taken_now = 1'b1;
      default: req_now = (timer_sat >= tss_pkg::TIMER_W'(read_interval_ms));
    endcase
  end

  // validation, runs and ring bookkeeping
  always_comb begin
    reading_x    = tss_pkg::CMP_W'(update.sensor_reading);
    in_range     = (reading_x != tss_pkg::DISCONNECTED) &&
                   (reading_x >= tss_pkg::CMP_W'(valid_min)) &&
                   (reading_x <= tss_pkg::CMP_W'(valid_max));
    accepted_now = taken_now && in_range;
    bad_inc      = (bad_run == tss_pkg::RUN_MAX) ? bad_run : bad_run + 1'b1;
    good_inc     = (good_run == tss_pkg::RUN_MAX) ? good_run : good_run + 1'b1;
    ws_inc       = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;

    last_good_temp_next = last_good_temp;
    bad_run_next        = bad_run;
    good_run_next       = good_run;
    operational_next    = operational;
    write_slot_next     = write_slot;
    filled_next         = filled;
    if (accepted_now) begin
      last_good_temp_next = update.sensor_reading;
      write_slot_next     = ws_inc;
      filled_next         = (filled == FULL) ? filled : filled + 1'b1;
      bad_run_next        = '0;
      good_run_next       = good_inc;
      if (good_inc >= recovery_threshold) begin
        operational_next = 1'b1;
        good_run_next    = '0;
      end
    end else if (taken_now) begin
      bad_run_next  = bad_inc;
      good_run_next = '0;
      if (bad_inc >= error_threshold) begin
        operational_next = 1'b0;
      end
    end

    hit_now = CW'(update.history_index) < CW'(filled_next);
    addr_a  = AW'(update.history_index);
    addr_b  = (filled_next == FULL) ? write_slot_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= tss_pkg::PH_IDLE;
      phase_timer    <= '0;
      last_good_temp <= '0;
      bad_run        <= '0;
      good_run       <= '0;
      write_slot     <= '0;
      filled         <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      phase_timer    <= phase_timer_next;
      last_good_temp <= last_good_temp_next;
      bad_run        <= bad_run_next;
      good_run       <= good_run_next;
      write_slot     <= write_slot_next;
      filled         <= filled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operational <= 1'b0;
    end else if (wr_en && wr_index == tss_pkg::REG_SENSOR_PRESENT) begin
      operational <= wr_data[0];
    end else if (accept) begin
      operational <= operational_next;
    end
  end

  tss_ring #(
    .DEPTH (RING_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_ring (
    .clk       (clk),
    .wr_en     (accept && accepted_now),
    .wr_addr   (write_slot),
    .wr_word   (update.sensor_reading),
    .rd_en     (accept),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_word_a (rd_a),
    .rd_word_b (rd_b)
  );

  // middle stage
  always_comb begin
    mid_next.request  = req_now;
    mid_next.taken    = taken_now;
    mid_next.accepted = accepted_now;
    mid_next.current  = last_good_temp_next;
    mid_next.ok       = operational_next;
    mid_next.errors   = bad_run_next;
    mid_next.fault    = (bad_run_next >= error_threshold);
    mid_next.count    = filled_next;
    mid_next.hit      = hit_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (accept) begin
      mid_valid <= 1'b1;
    end else if (mid_adv) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mid <= mid_next;
    end
  end

  // report register
  always_comb begin
    rep_next.request  = mid.request;
    rep_next.taken    = mid.taken;
    rep_next.accepted = mid.accepted;
    rep_next.current  = mid.current;
    rep_next.ok       = mid.ok;
    rep_next.errors   = mid.errors;
    rep_next.fault    = mid.fault;
    rep_next.count    = tss_pkg::COUNT_W'(mid.count);
    rep_next.hit      = mid.hit;
    rep_next.hist     = mid.hit ? $signed(rd_a) : '0;
    rep_next.oldest   = (mid.count != '0) ? $signed(rd_b) : '0;
    rep_next.newest   = (mid.count != '0) ? mid.current : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_valid <= 1'b0;
    end else if (mid_adv) begin
      rep_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv && mid_valid) begin
      rep <= rep_next;
    end
  end

  assign report.valid              = rep_valid;
  assign report.request_conversion = rep.request;
  assign report.sample_taken       = rep.taken;
  assign report.sample_accepted    = rep.accepted;
  assign report.current_temp       = rep.current;
  assign report.sensor_ok          = rep.ok;
  assign report.error_count        = rep.errors;
  assign report.sensor_fault       = rep.fault;
  assign report.history_count      = rep.count;
  assign report.history_value      = rep.hist;
  assign report.history_hit        = rep.hit;
  assign report.oldest_temp        = rep.oldest;
  assign report.newest_temp        = rep.newest;

  a_proc_to_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == tss_pkg::PH_PROC) |=> phase == tss_pkg::PH_IDLE)
    else $error("process phase did not return to idle");

  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (mid_valid && !mid_adv) |=> mid_valid)
    else $error("middle stage lost a word while stalled");

  a_slot_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && accepted_now) |=> write_slot == $past(ws_inc))
    else $error("write slot did not advance on an accepted reading");

  a_reject_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && taken_now && !in_range) |=> (bad_run != '0 && good_run == '0))
    else $error("rejected reading did not update the runs");

endmodule
